### design/rrts_pkg.sv
// Shared types and codes of the round-robin thread scheduler.
// No dependencies; used by rrts_core and round_robin_thread_scheduler_top.
`default_nettype none

package rrts_pkg;

  localparam int ID_W = 7;
  localparam int QW   = 32;
  localparam int TW   = 24;

  // actions
  localparam logic [2:0] A_TICK   = 3'd0;
  localparam logic [2:0] A_SPAWN  = 3'd1;
  localparam logic [2:0] A_TERM   = 3'd2;
  localparam logic [2:0] A_BLOCK  = 3'd3;
  localparam logic [2:0] A_RESUME = 3'd4;
  localparam logic [2:0] A_LOCK   = 3'd5;
  localparam logic [2:0] A_UNLOCK = 3'd6;
  localparam logic [2:0] A_QUERY  = 3'd7;

  // result status
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ILLEGAL = 3'd1;
  localparam logic [2:0] ST_NOFREE  = 3'd2;
  localparam logic [2:0] ST_MUTEX   = 3'd3;
  localparam logic [2:0] ST_ENDED   = 3'd4;

  // thread states
  localparam logic [1:0] TS_FREE    = 2'd0;
  localparam logic [1:0] TS_READY   = 2'd1;
  localparam logic [1:0] TS_RUNNING = 2'd2;
  localparam logic [1:0] TS_BLOCKED = 2'd3;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DEC, S_SCAN, S_REM, S_REL, S_REL1, S_REL2,
    S_DISP, S_DSP1, S_DSP2, S_FIN
  } rrts_state_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [ID_W-1:0] new_id;
    logic [ID_W-1:0] run_id;
    logic            run_v;
    logic [QW-1:0]   tq;
    logic [QW-1:0]   total;
    logic            sw;
  } rrts_res_t;

endpackage

`default_nettype wire

### design/rrts_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module rrts_ram #(
  parameter int W = 8,
  parameter int D = 128
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/rrts_core.sv
// Scheduler sequencer: thread state, quanta and both FIFO rings in RAMs,
// read-modify-write over a step sequence. Depends on rrts_pkg, rrts_ram.
`default_nettype none

module rrts_core import rrts_pkg::*; #(
  parameter int THREADS = 128
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [2:0]      act,
  input  wire logic [ID_W-1:0] tid,
  input  wire logic [TW-1:0]   qt,
  input  wire logic            res_ready,
  output logic                 idle,
  output logic                 res_valid,
  output rrts_res_t            res
);

  localparam int IW = $clog2(THREADS);
  localparam int CW = IW + 1;
  localparam int XW = IW + ID_W;

  function automatic logic [IW-1:0] addm(input logic [IW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(THREADS)) begin
      s = s - (CW+1)'(THREADS);
    end
    return s[IW-1:0];
  endfunction

  rrts_state_t state_r, state_nxt;

  logic [2:0]      act_r, act_nxt;
  logic [ID_W-1:0] tid_r, tid_nxt;
  logic [IW-1:0]   rhead_r, rhead_nxt, whead_r, whead_nxt;
  logic [CW-1:0]   rcount_r, rcount_nxt, wcount_r, wcount_nxt;
  logic [IW-1:0]   cur_r, cur_nxt, mowner_r, mowner_nxt;
  logic            curv_r, curv_nxt, mheld_r, mheld_nxt;
  logic [QW-1:0]   qtot_r, qtot_nxt;
  logic [TW-1:0]   ticks_r, ticks_nxt;
  logic [CW-1:0]   sc_r, sc_nxt, pos_r, pos_nxt;
  logic            chk_r, chk_nxt, found_r, found_nxt;
  logic            remw_r, remw_nxt, relp_r, relp_nxt, term_r, term_nxt;
  logic [IW-1:0]   clr_r, clr_nxt;
  logic [IW-1:0]   hole_r, hole_nxt, ra_r, ra_nxt, rw_r, rw_nxt, n_r, n_nxt;
  logic [2:0]      status_r, status_nxt;
  logic [IW-1:0]   new_r, new_nxt;
  logic [QW-1:0]   tq_r, tq_nxt;
  logic            sw_r, sw_nxt;

  logic            s_we, q_we, r_we, w_we;
  logic [IW-1:0]   s_wa, s_ra, q_wa, q_ra, r_wa, r_ra, w_wa, w_ra;
  logic [2:0]      s_wd, s_rd;
  logic [QW-1:0]   q_wd, q_rd;
  logic [IW-1:0]   r_wd, r_rd, w_wd, w_rd;
  logic            pr_en, pw_en;
  logic [IW-1:0]   pr_id, pw_id;

  rrts_ram #(.W(3),  .D(THREADS)) u_stat (.clk, .we(s_we), .waddr(s_wa), .wdata(s_wd),
                                          .raddr(s_ra), .rdata(s_rd));
  rrts_ram #(.W(QW), .D(THREADS)) u_qnt  (.clk, .we(q_we), .waddr(q_wa), .wdata(q_wd),
                                          .raddr(q_ra), .rdata(q_rd));
  rrts_ram #(.W(IW), .D(THREADS)) u_rdy  (.clk, .we(r_we), .waddr(r_wa), .wdata(r_wd),
                                          .raddr(r_ra), .rdata(r_rd));
  rrts_ram #(.W(IW), .D(THREADS)) u_wait (.clk, .we(w_we), .waddr(w_wa), .wdata(w_wd),
                                          .raddr(w_ra), .rdata(w_rd));

  // decode of the target entry read in the first step
  logic [XW-1:0] tid_w, tin_w, cur_w, new_w;
  logic [IW-1:0] tidx;
  logic [1:0]    tst;
  logic          twait, legal, tzero, term_rel;
  logic [TW-1:0] tick_inc, qeff;
  logic [CW-1:0] rem_cnt;
  logic [IW-1:0] rem_hd, rem_d;
  logic          rem_match, rem_done, sc_free, sc_end;

  assign tid_w     = XW'(tid_r);
  assign tin_w     = XW'(tid);
  assign tidx      = tid_w[IW-1:0];
  assign tst       = s_rd[1:0];
  assign twait     = s_rd[2];
  assign legal     = (tid_w < XW'(THREADS)) && (tst != TS_FREE);
  assign tzero     = (tidx == '0);
  assign term_rel  = mheld_r && (mowner_r == tidx);
  assign tick_inc  = ticks_r + TW'(1);
  assign qeff      = (qt == '0) ? TW'(1) : qt;
  assign rem_cnt   = remw_r ? wcount_r : rcount_r;
  assign rem_hd    = remw_r ? whead_r : rhead_r;
  assign rem_d     = remw_r ? w_rd : r_rd;
  assign rem_match = (pos_r != '0) && !found_r && (rem_d == tidx);
  assign rem_done  = (pos_r == rem_cnt);
  assign sc_free   = chk_r && (s_rd[1:0] == TS_FREE);
  assign sc_end    = chk_r && (sc_r == CW'(THREADS));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_r == IW'(THREADS - 1)) state_nxt = term_r ? S_FIN : S_IDLE;
      S_IDLE: if (start) state_nxt = S_DEC;
      S_DEC: begin
        case (act_r)
          A_SPAWN: state_nxt = S_SCAN;
          A_TERM: begin
            if (!legal)                            state_nxt = S_DISP;
            else if (tzero)                        state_nxt = S_CLR;
            else if (twait || (tst == TS_READY))   state_nxt = S_REM;
            else if (term_rel)                     state_nxt = S_REL;
            else                                   state_nxt = S_DISP;
          end
          A_BLOCK: state_nxt = (legal && !tzero && tst == TS_READY && !twait) ? S_REM : S_DISP;
          A_UNLOCK: state_nxt = (mheld_r && curv_r && mowner_r == cur_r) ? S_REL : S_DISP;
          default: state_nxt = S_DISP;
        endcase
      end
      S_SCAN: if (sc_free || sc_end) state_nxt = S_DISP;
      S_REM:  if (rem_done) state_nxt = relp_r ? S_REL : S_DISP;
      S_REL:  state_nxt = (wcount_r == '0) ? S_DISP : S_REL1;
      S_REL1: state_nxt = S_REL2;
      S_REL2: state_nxt = S_DISP;
      S_DISP: state_nxt = (!curv_r && rcount_r != '0) ? S_DSP1 : S_FIN;
      S_DSP1: state_nxt = S_DSP2;
      S_DSP2: state_nxt = S_FIN;
      S_FIN:  if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    act_nxt = act_r;     tid_nxt = tid_r;
    rhead_nxt = rhead_r; rcount_nxt = rcount_r;
    whead_nxt = whead_r; wcount_nxt = wcount_r;
    cur_nxt = cur_r;     curv_nxt = curv_r;
    mheld_nxt = mheld_r; mowner_nxt = mowner_r;
    qtot_nxt = qtot_r;   ticks_nxt = ticks_r;
    sc_nxt = sc_r;       chk_nxt = chk_r;
    pos_nxt = pos_r;     found_nxt = found_r;
    remw_nxt = remw_r;   relp_nxt = relp_r;   term_nxt = term_r;
    clr_nxt = clr_r;     hole_nxt = hole_r;   ra_nxt = ra_r;
    rw_nxt = rw_r;       n_nxt = n_r;
    status_nxt = status_r; new_nxt = new_r; tq_nxt = tq_r; sw_nxt = sw_r;
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
    q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
    r_we = 1'b0; r_wa = '0; r_wd = '0; r_ra = '0;
    w_we = 1'b0; w_wa = '0; w_wd = '0; w_ra = '0;
    pr_en = 1'b0; pr_id = '0; pw_en = 1'b0; pw_id = '0;

    case (state_r)
      S_CLR: begin
        s_we = 1'b1; s_wa = clr_r;
        s_wd = (clr_r == '0) ? {1'b0, TS_RUNNING} : {1'b0, TS_FREE};
        q_we = 1'b1; q_wa = clr_r;
        q_wd = (clr_r == '0) ? QW'(1) : '0;
        clr_nxt = clr_r + IW'(1);
      end
      S_IDLE: begin
        s_ra = tin_w[IW-1:0];
        q_ra = tin_w[IW-1:0];
        if (start) begin
          act_nxt = act; tid_nxt = tid; term_nxt = 1'b0;
          status_nxt = ST_OK; new_nxt = '0; tq_nxt = '0; sw_nxt = 1'b0;
        end
      end
      S_DEC: begin
        pos_nxt = '0; found_nxt = 1'b0;
        case (act_r)
          A_TICK: begin
            ticks_nxt = tick_inc;
            if (tick_inc >= qeff) begin
              ticks_nxt = '0;
              if (curv_r) begin
                s_we = 1'b1; s_wa = cur_r; s_wd = {1'b0, TS_READY};
                pr_en = 1'b1; pr_id = cur_r; curv_nxt = 1'b0;
              end
            end
          end
          A_SPAWN: begin
            sc_nxt = CW'(1); chk_nxt = 1'b0;
          end
          A_TERM: begin
            if (!legal) begin
              status_nxt = ST_ILLEGAL;
            end else if (tzero) begin
              status_nxt = ST_ENDED; term_nxt = 1'b1; clr_nxt = '0;
              rhead_nxt = '0; rcount_nxt = '0; whead_nxt = '0; wcount_nxt = '0;
              cur_nxt = '0; curv_nxt = 1'b1; mheld_nxt = 1'b0; mowner_nxt = '0;
              qtot_nxt = QW'(1); ticks_nxt = '0;
            end else begin
              s_we = 1'b1; s_wa = tidx; s_wd = {1'b0, TS_FREE};
              if (curv_r && cur_r == tidx) curv_nxt = 1'b0;
              relp_nxt = term_rel;
              remw_nxt = twait;
            end
          end
          A_BLOCK: begin
            if (!legal || tzero) begin
              status_nxt = ST_ILLEGAL;
            end else if (tst == TS_READY) begin
              s_we = 1'b1; s_wa = tidx; s_wd = {twait, TS_BLOCKED};
              remw_nxt = 1'b0; relp_nxt = 1'b0;
            end else if (tst == TS_RUNNING) begin
              s_we = 1'b1; s_wa = tidx; s_wd = {1'b0, TS_BLOCKED};
              curv_nxt = 1'b0;
            end
          end
          A_RESUME: begin
            if (!legal) begin
              status_nxt = ST_ILLEGAL;
            end else if (tst == TS_BLOCKED) begin
              s_we = 1'b1; s_wa = tidx; s_wd = {twait, TS_READY};
              if (!twait) begin
                pr_en = 1'b1; pr_id = tidx;
              end
            end
          end
          A_LOCK: begin
            if (!curv_r || (mheld_r && mowner_r == cur_r)) begin
              status_nxt = ST_MUTEX;
            end else if (!mheld_r) begin
              mheld_nxt = 1'b1; mowner_nxt = cur_r;
            end else begin
              s_we = 1'b1; s_wa = cur_r; s_wd = {1'b1, TS_READY};
              pw_en = 1'b1; pw_id = cur_r; curv_nxt = 1'b0;
            end
          end
          A_UNLOCK: begin
            if (!mheld_r) status_nxt = ST_MUTEX;
          end
          default: begin
            if (!legal) status_nxt = ST_ILLEGAL;
            else        tq_nxt = q_rd;
          end
        endcase
      end
      S_SCAN: begin
        if (sc_r < CW'(THREADS)) s_ra = sc_r[IW-1:0];
        chk_nxt = 1'b1;
        sc_nxt = sc_r + CW'(1);
        if (sc_free) begin
          s_we = 1'b1; s_wa = sc_nxt[IW-1:0] - IW'(2); s_wd = {1'b0, TS_READY};
          q_we = 1'b1; q_wa = s_wa; q_wd = '0;
          pr_en = 1'b1; pr_id = s_wa; new_nxt = s_wa;
        end else if (sc_end) begin
          status_nxt = ST_NOFREE;
        end
      end
      S_REM: begin
        if (pos_r < rem_cnt) begin
          ra_nxt = addm(rem_hd, pos_r);
          r_ra = ra_nxt; w_ra = ra_nxt;
        end
        pos_nxt = pos_r + CW'(1);
        if (pos_r != '0 && found_r) begin
          hole_nxt = ra_r;
          if (remw_r) begin
            w_we = 1'b1; w_wa = hole_r; w_wd = rem_d;
          end else begin
            r_we = 1'b1; r_wa = hole_r; r_wd = rem_d;
          end
        end else if (rem_match) begin
          found_nxt = 1'b1; hole_nxt = ra_r;
        end
        if (rem_done && (found_r || rem_match)) begin
          if (remw_r) wcount_nxt = wcount_r - CW'(1);
          else        rcount_nxt = rcount_r - CW'(1);
        end
      end
      S_REL: begin
        w_ra = whead_r;
        if (wcount_r == '0) begin
          mheld_nxt = 1'b0; mowner_nxt = '0;
        end
      end
      S_REL1: begin
        whead_nxt = addm(whead_r, CW'(1));
        wcount_nxt = wcount_r - CW'(1);
        mowner_nxt = w_rd; rw_nxt = w_rd; s_ra = w_rd;
      end
      S_REL2: begin
        s_we = 1'b1; s_wa = rw_r; s_wd = {1'b0, s_rd[1:0]};
        if (s_rd[1:0] == TS_READY) begin
          pr_en = 1'b1; pr_id = rw_r;
        end
      end
      S_DISP: begin
        r_ra = rhead_r;
      end
      S_DSP1: begin
        rhead_nxt = addm(rhead_r, CW'(1));
        rcount_nxt = rcount_r - CW'(1);
        cur_nxt = r_rd; curv_nxt = 1'b1; ticks_nxt = '0; sw_nxt = 1'b1;
        qtot_nxt = (qtot_r == '1) ? qtot_r : qtot_r + QW'(1);
        s_we = 1'b1; s_wa = r_rd; s_wd = {1'b0, TS_RUNNING};
        q_ra = r_rd; n_nxt = r_rd;
      end
      S_DSP2: begin
        q_we = 1'b1; q_wa = n_r;
        q_wd = (q_rd == '1) ? q_rd : q_rd + QW'(1);
      end
      default: begin
      end
    endcase

    if (pr_en && rcount_r < CW'(THREADS)) begin
      r_we = 1'b1; r_wa = addm(rhead_r, rcount_r); r_wd = pr_id;
      rcount_nxt = rcount_r + CW'(1);
    end
    if (pw_en && wcount_r < CW'(THREADS)) begin
      w_we = 1'b1; w_wa = addm(whead_r, wcount_r); w_wd = pw_id;
      wcount_nxt = wcount_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      rhead_r <= '0; rcount_r <= '0; whead_r <= '0; wcount_r <= '0;
      cur_r <= '0; curv_r <= 1'b1; mheld_r <= 1'b0; mowner_r <= '0;
      qtot_r <= QW'(1); ticks_r <= '0;
      sc_r <= '0; chk_r <= 1'b0; pos_r <= '0; found_r <= 1'b0;
      remw_r <= 1'b0; relp_r <= 1'b0; term_r <= 1'b0; clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      rhead_r <= rhead_nxt; rcount_r <= rcount_nxt;
      whead_r <= whead_nxt; wcount_r <= wcount_nxt;
      cur_r <= cur_nxt; curv_r <= curv_nxt;
      mheld_r <= mheld_nxt; mowner_r <= mowner_nxt;
      qtot_r <= qtot_nxt; ticks_r <= ticks_nxt;
      sc_r <= sc_nxt; chk_r <= chk_nxt; pos_r <= pos_nxt; found_r <= found_nxt;
      remw_r <= remw_nxt; relp_r <= relp_nxt; term_r <= term_nxt; clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt; tid_r <= tid_nxt;
    hole_r <= hole_nxt; ra_r <= ra_nxt; rw_r <= rw_nxt; n_r <= n_nxt;
    status_r <= status_nxt; new_r <= new_nxt; tq_r <= tq_nxt; sw_r <= sw_nxt;
  end

  assign cur_w = XW'(cur_r);
  assign new_w = XW'(new_r);

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);

  always_comb begin
    res.status = status_r;
    res.new_id = new_w[ID_W-1:0];
    res.run_id = curv_r ? cur_w[ID_W-1:0] : '0;
    res.run_v  = curv_r;
    res.tq     = tq_r;
    res.total  = qtot_r;
    res.sw     = sw_r;
  end

endmodule

`default_nettype wire

### design/round_robin_thread_scheduler_top.sv
// Top level of the round-robin thread scheduler: stream ports, quantum
// register and result register. Depends on rrts_pkg, rrts_core.
//
//  channel | signals                                | direction
//  in      | in_tvalid/in_tready/in_tdata/in_tuser  | request items
//  out     | out_tvalid/out_tready/out_tdata        | one result item per request
//  cfg     | cfg_valid/cfg_ready/cfg_data           | quantum_ticks write
//
// Spawn scans the state RAM; removing a thread from a FIFO walks its ring RAM.
// After reset and after terminating thread 0 a clearing pass over the state
// and quanta RAMs runs with in_tready low.
// A held result does not block the next request; the sequencer waits at its end.
`default_nettype none

module round_robin_thread_scheduler_top import rrts_pkg::*; #(
  parameter int THREADS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [6:0] thread_id
  input  wire logic [2:0]  in_tuser,   // [2:0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // status, new_thread_id, running_id,
                                       // running_valid, thread_quanta,
                                       // total_quanta, switched
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [23:0] cfg_data
);

  logic [TW-1:0] qt_r;
  logic          out_tvalid_r;
  logic [87:0]   out_tdata_r;
  logic          core_idle, res_valid, res_ready, start;
  rrts_res_t     res;

  assign in_tready = core_idle;
  assign start     = in_tvalid && core_idle;
  assign cfg_ready = 1'b1;
  assign res_ready = !out_tvalid_r || out_tready;

  rrts_core #(.THREADS(THREADS)) u_core (
    .clk, .rst_n, .start,
    .act(in_tuser), .tid(in_tdata[ID_W-1:0]), .qt(qt_r),
    .res_ready, .idle(core_idle), .res_valid, .res
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qt_r <= TW'(1000);
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) qt_r <= cfg_data;
      if (res_ready) out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_tdata_r <= {5'b0, res.sw, res.total, res.tq, res.run_v, res.run_id,
                      res.new_id, res.status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= ST_ENDED) else $error("bad status code");

  a_idle_runner: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[17] |-> out_tdata[16:10] == 7'd0 && !out_tdata[82])
    else $error("no runner but id or switch set");

  a_ended: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == ST_ENDED |->
      out_tdata[17] && out_tdata[16:10] == 7'd0 && out_tdata[81:50] == 32'd1)
    else $error("end of process not back at reset state");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("item taken while busy");

endmodule

`default_nettype wire

### tb/sv/round_robin_thread_scheduler_top_test.sv
// Self-checking testbench for round_robin_thread_scheduler_top: directed table
// then random scheduler actions, checked against a predictor. Needs rrts_pkg.
`timescale 1ns / 100ps

module round_robin_thread_scheduler_top_test;
  import rrts_pkg::*;

  localparam int NTHR = 128;
  localparam int WATCH_LIMIT = 20000;
  localparam int SETTLE = 300;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic [2:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [87:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [23:0] cfg_data;

  round_robin_thread_scheduler_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // scheduler mirror
  logic [23:0] sch_quantum;
  logic [1:0] sch_state [NTHR];
  logic sch_waiting [NTHR];
  logic [6:0] sch_ready_q [$];
  logic [6:0] sch_wait_q [$];
  logic [6:0] sch_cur;
  logic sch_cur_v;
  logic sch_mtx_held;
  logic [6:0] sch_mtx_owner;
  logic [31:0] sch_quanta [NTHR];
  logic [31:0] sch_total;
  logic [23:0] sch_ticks;

  rrts_res_t expected_results [$];
  int fixed_status [$];
  int fails = 0;
  int checked = 0;
  int idle_cycles = 0;
  bit no_idle = 0;
  bit hold_req = 0;
  bit hold_off = 0;
  int n_switch = 0;
  int n_err = 0;

  typedef struct {
    logic [2:0] act;
    logic [6:0] tid;
    int status;
  } dir_row_t;

  dir_row_t dir_tbl [] = '{
    '{A_QUERY, 7'd0, -1}, '{A_QUERY, 7'd5, ST_ILLEGAL}, '{A_QUERY, 7'd127, ST_ILLEGAL},
    '{A_SPAWN, 7'd0, ST_OK}, '{A_BLOCK, 7'd0, ST_ILLEGAL}, '{A_UNLOCK, 7'd0, ST_MUTEX},
    '{A_LOCK, 7'd0, ST_OK}, '{A_LOCK, 7'd0, ST_MUTEX}, '{A_RESUME, 7'd1, ST_OK},
    '{A_BLOCK, 7'd1, ST_OK}, '{A_BLOCK, 7'd1, ST_OK}, '{A_SPAWN, 7'd0, -1},
    '{A_TERM, 7'd127, ST_ILLEGAL}, '{A_TICK, 7'd0, -1}, '{A_TICK, 7'd0, -1},
    '{A_LOCK, 7'd0, -1}, '{A_RESUME, 7'd1, -1}, '{A_TICK, 7'd0, -1},
    '{A_TICK, 7'd0, -1}, '{A_UNLOCK, 7'd0, -1}, '{A_TERM, 7'd2, -1},
    '{A_QUERY, 7'd1, -1}, '{A_RESUME, 7'd64, ST_ILLEGAL}, '{A_TERM, 7'd0, ST_ENDED},
    '{A_QUERY, 7'd0, -1}
  };

  function automatic logic [31:0] sat_inc(logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  task automatic sched_clear();
    for (int i = 0; i < NTHR; i++) begin
      sch_state[i] = TS_FREE;
      sch_waiting[i] = 0;
      sch_quanta[i] = 0;
    end
    sch_ready_q.delete();
    sch_wait_q.delete();
    sch_state[0] = TS_RUNNING;
    sch_cur = 0;
    sch_cur_v = 1;
    sch_mtx_held = 0;
    sch_mtx_owner = 0;
    sch_quanta[0] = 1;
    sch_total = 1;
    sch_ticks = 0;
  endtask

  task automatic q_remove(ref logic [6:0] q [$], input logic [6:0] id);
    for (int i = 0; i < q.size(); i++)
      if (q[i] == id) begin
        q.delete(i);
        return;
      end
  endtask

  task automatic mutex_pass();
    logic [6:0] w;
    if (sch_wait_q.size() == 0) begin
      sch_mtx_held = 0;
      sch_mtx_owner = 0;
    end else begin
      w = sch_wait_q[0];
      sch_wait_q.delete(0);
      sch_waiting[w] = 0;
      sch_mtx_owner = w;
      if (sch_state[w] == TS_READY && sch_ready_q.size() < NTHR) sch_ready_q = {sch_ready_q, w};
    end
  endtask

  task automatic sched_step(input logic [2:0] act, input logic [6:0] t, output rrts_res_t r);
    logic legal;
    logic [23:0] q;
    logic [6:0] n;
    r = '0;
    legal = sch_state[t] != TS_FREE;
    case (act)
      A_TICK: begin
        q = (sch_quantum == 0) ? 24'd1 : sch_quantum;
        sch_ticks = sch_ticks + 24'd1;
        if (sch_ticks >= q) begin
          sch_ticks = 0;
          if (sch_cur_v) begin
            sch_state[sch_cur] = TS_READY;
            if (sch_ready_q.size() < NTHR) sch_ready_q = {sch_ready_q, sch_cur};
            sch_cur_v = 0;
          end
        end
      end
      A_SPAWN: begin
        r.status = ST_NOFREE;
        for (int i = 1; i < NTHR; i++)
          if (sch_state[i] == TS_FREE) begin
            sch_state[i] = TS_READY;
            sch_waiting[i] = 0;
            sch_quanta[i] = 0;
            if (sch_ready_q.size() < NTHR) sch_ready_q = {sch_ready_q, 7'(i)};
            r.new_id = 7'(i);
            r.status = ST_OK;
            break;
          end
      end
      A_TERM: begin
        if (!legal) r.status = ST_ILLEGAL;
        else if (t == 0) begin
          sched_clear();
          r.status = ST_ENDED;
        end else begin
          if (sch_waiting[t]) begin
            q_remove(sch_wait_q, t);
            sch_waiting[t] = 0;
          end else if (sch_state[t] == TS_READY) q_remove(sch_ready_q, t);
          if (sch_mtx_held && sch_mtx_owner == t) mutex_pass();
          if (sch_cur_v && sch_cur == t) sch_cur_v = 0;
          sch_state[t] = TS_FREE;
        end
      end
      A_BLOCK: begin
        if (!legal || t == 0) r.status = ST_ILLEGAL;
        else if (sch_state[t] == TS_READY) begin
          if (!sch_waiting[t]) q_remove(sch_ready_q, t);
          sch_state[t] = TS_BLOCKED;
        end else if (sch_state[t] == TS_RUNNING) begin
          sch_state[t] = TS_BLOCKED;
          sch_cur_v = 0;
        end
      end
      A_RESUME: begin
        if (!legal) r.status = ST_ILLEGAL;
        else if (sch_state[t] == TS_BLOCKED) begin
          sch_state[t] = TS_READY;
          if (!sch_waiting[t] && sch_ready_q.size() < NTHR) sch_ready_q = {sch_ready_q, t};
        end
      end
      A_LOCK: begin
        if (!sch_cur_v || (sch_mtx_held && sch_mtx_owner == sch_cur)) r.status = ST_MUTEX;
        else if (!sch_mtx_held) begin
          sch_mtx_held = 1;
          sch_mtx_owner = sch_cur;
        end else begin
          sch_state[sch_cur] = TS_READY;
          sch_waiting[sch_cur] = 1;
          if (sch_wait_q.size() < NTHR) sch_wait_q = {sch_wait_q, sch_cur};
          sch_cur_v = 0;
        end
      end
      A_UNLOCK: begin
        if (!sch_mtx_held) r.status = ST_MUTEX;
        else if (sch_cur_v && sch_mtx_owner == sch_cur) mutex_pass();
      end
      default: begin
        if (!legal) r.status = ST_ILLEGAL;
        else r.tq = sch_quanta[t];
      end
    endcase
    if (!sch_cur_v && sch_ready_q.size() > 0) begin
      n = sch_ready_q[0];
      sch_ready_q.delete(0);
      sch_cur = n;
      sch_cur_v = 1;
      sch_state[n] = TS_RUNNING;
      sch_quanta[n] = sat_inc(sch_quanta[n]);
      sch_total = sat_inc(sch_total);
      sch_ticks = 0;
      r.sw = 1;
    end
    r.run_id = sch_cur_v ? sch_cur : 7'd0;
    r.run_v = sch_cur_v;
    r.total = sch_total;
  endtask

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  task automatic send_action(input logic [2:0] act, input logic [6:0] t, input int fixed);
    rrts_res_t r;
    if (!no_idle && $urandom_range(99) < 22) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= act;
    in_tdata <= {1'b0, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sched_step(act, t, r);
    if (r.sw) n_switch++;
    if (r.status != ST_OK) n_err++;
    expected_results = {expected_results, r};
    fixed_status = {fixed_status, fixed};
  endtask

  task automatic write_quantum(input logic [23:0] v);
    in_tvalid <= 0;
    wait (expected_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sch_quantum = v;
  endtask

  task automatic random_action(input int spawn_pct);
    logic [2:0] act;
    logic [6:0] t;
    int p;
    p = $urandom_range(99);
    if (p < spawn_pct) act = A_SPAWN;
    else begin
      p = $urandom_range(99);
      act = p < 30 ? A_TICK : p < 40 ? A_SPAWN : p < 48 ? A_TERM : p < 60 ? A_BLOCK :
            p < 72 ? A_RESUME : p < 84 ? A_LOCK : p < 94 ? A_UNLOCK : A_QUERY;
    end
    t = ($urandom_range(99) < 15) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 12));
    if ($urandom_range(99) < 5) t = 0;
    if (act == A_TERM && t == 0 && $urandom_range(99) > 2) t = 1;
    send_action(act, t, -1);
  endtask

  // receiver
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (hold_off) out_tready <= 0;
    else out_tready <= no_idle || ($urandom_range(99) >= 22);
  end

  initial begin
    wait (rst_n);
    wait (hold_req);
    hold_off = 1;
    repeat (1500) @(posedge clk);
    hold_off = 0;
  end

  // result checker
  always @(posedge clk) begin
    rrts_res_t e;
    int fx;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no item pending, got %h", $time, out_tdata);
        fails++;
      end else begin
        e = expected_results[0];
        expected_results.delete(0);
        fx = fixed_status[0];
        fixed_status.delete(0);
        checked++;
        if (fx >= 0 && out_tdata[2:0] != fx[2:0]) begin
          $display("%0t: table status exp %0d got %0d", $time, fx, out_tdata[2:0]);
          fails++;
        end
        if (out_tdata[2:0] != e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_tdata[2:0]);
          fails++;
        end
        if (out_tdata[9:3] != e.new_id) begin
          $display("%0t: new_thread_id exp %0d got %0d", $time, e.new_id, out_tdata[9:3]);
          fails++;
        end
        if (out_tdata[16:10] != e.run_id) begin
          $display("%0t: running_id exp %0d got %0d", $time, e.run_id, out_tdata[16:10]);
          fails++;
        end
        if (out_tdata[17] != e.run_v) begin
          $display("%0t: running_valid exp %0d got %0d", $time, e.run_v, out_tdata[17]);
          fails++;
        end
        if (out_tdata[49:18] != e.tq) begin
          $display("%0t: thread_quanta exp %0d got %0d", $time, e.tq, out_tdata[49:18]);
          fails++;
        end
        if (out_tdata[81:50] != e.total) begin
          $display("%0t: total_quanta exp %0d got %0d", $time, e.total, out_tdata[81:50]);
          fails++;
        end
        if (out_tdata[82] != e.sw) begin
          $display("%0t: switched exp %0d got %0d", $time, e.sw, out_tdata[82]);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("%0t: no progress, timeout", $time);
      $display("round_robin_thread_scheduler_top_test NOT OK");
      $finish;
    end
  end

  initial begin
    logic [23:0] quanta_set [5] = '{24'd1, 24'd3, 24'hFFFFFF, 24'd0, 24'd7};
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = 0;
    cfg_valid = 0;
    cfg_data = 0;
    sch_quantum = 24'd1000;
    sched_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    write_quantum(24'd2);
    foreach (dir_tbl[i]) send_action(dir_tbl[i].act, dir_tbl[i].tid, dir_tbl[i].status);

    foreach (quanta_set[ph]) begin
      write_quantum(quanta_set[ph]);
      if (ph == 0) hold_req = 1;
      no_idle = (ph == 3);
      if (ph == 2) repeat (135) random_action(100);
      repeat (360) random_action(ph == 2 ? 0 : 5);
      no_idle = 0;
    end
    write_quantum(24'd1000);
    repeat (20) random_action(5);
    in_tvalid <= 0;

    wait (expected_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
    $display("checked %0d results: %0d context switches, %0d error statuses",
             checked, n_switch, n_err);
    $display("quantum settings 0, 1, 2, 3, 7, 1000 and max; one long output stall");
    if (fails == 0 && expected_results.size() == 0) begin
      $display("round_robin_thread_scheduler_top_test OK");
    end else begin
      $display("round_robin_thread_scheduler_top_test NOT OK");
    end
    $finish;
  end

endmodule
